[hw/rtl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants and controller/datapath types for the binary to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_BITS = 32;
	// Decimal digits of 2^VALUE_BITS-1: floor(VALUE_BITS*log10(2))+1
	localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_BITS   = DIGITS * 4;
	localparam int CNT_BITS   = $clog2(VALUE_BITS);
	localparam int LEFT_BITS  = $clog2(DIGITS + 1);

	localparam logic [5:0] DIGIT_BASE   = 6'd48;
	localparam logic [3:0] DABBLE_LIMIT = 4'd5;
	localparam logic [3:0] DABBLE_ADD   = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic last_bit;
		logic top_zero;
		logic last_digit;
	} dp_stat_t;

endpackage

[hw/rtl/b2da_in_if.sv]
// ----------------------------------------------------------------------------
// b2da_in_if
// Request channel carrying one binary number.
// ----------------------------------------------------------------------------
interface b2da_in_if import b2da_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);

endinterface

[hw/rtl/b2da_out_if.sv]
// ----------------------------------------------------------------------------
// b2da_out_if
// Request channel carrying one ASCII digit and its last flag.
// ----------------------------------------------------------------------------
interface b2da_out_if ();

	logic       valid;
	logic       ready;
	logic [5:0] ascii_digit;
	logic       last;

	modport source (output valid, output ascii_digit, output last, input ready);
	modport sink (input valid, input ascii_digit, input last, output ready);

endinterface

[hw/rtl/binary_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary number to decimal ASCII digits, most
// significant first, no leading zeros, last flag on the final digit.
//
//   channel  dir  payload                      one request is
//   number   in   value[VALUE_BITS-1:0]        a number to convert
//   text     out  ascii_digit[5:0], last       one decimal digit
//
// An item passes an accept state, VALUE_BITS double-dabble shifts, a skip
// state that drops leading zeros one at a time, then the digit output state.
// Reset (arst_n low) returns the controller to idle and discards any item.
// A stall on text holds the current digit; number is not taken until the
// last digit of the previous item is delivered.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top import b2da_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	b2da_in_if.sink   number,
	b2da_out_if.source text
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	b2da_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	b2da_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (number.value),
		.stat        (stat),
		.ascii_digit (text.ascii_digit),
		.last        (text.last)
	);

endmodule

[hw/rtl/b2da_dp.sv]
// ----------------------------------------------------------------------------
// b2da_dp
// Datapath: bit-serial double-dabble BCD register, leading zero drop and
// digit shift-out.
// ----------------------------------------------------------------------------
module b2da_dp import b2da_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [VALUE_BITS-1:0] value,
	output dp_stat_t              stat,
	output logic [5:0]            ascii_digit,
	output logic                  last
);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCD_BITS-1:0]   dab;
	logic [CNT_BITS-1:0]   bit_cnt_q;
	logic [LEFT_BITS-1:0]  left_q;
	logic [3:0]            top_nib;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= DABBLE_LIMIT) begin
				dab[i*4 +: 4] = bcd_q[i*4 +: 4] + DABBLE_ADD;
			end else begin
				dab[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {dab[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.advance) begin
			bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			left_q    <= LEFT_BITS'(DIGITS);
		end else if (cmd.load) begin
			bit_cnt_q <= CNT_BITS'(VALUE_BITS - 1);
			left_q    <= LEFT_BITS'(DIGITS);
		end else if (cmd.step) begin
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end else if (cmd.advance) begin
			left_q <= left_q - 1'b1;
		end
	end

	assign top_nib         = bcd_q[BCD_BITS-1 -: 4];
	assign stat.last_bit   = (bit_cnt_q == '0);
	assign stat.top_zero   = (top_nib == 4'd0);
	assign stat.last_digit = (left_q == LEFT_BITS'(1));
	assign ascii_digit     = DIGIT_BASE + {2'b00, top_nib};
	assign last            = stat.last_digit;

endmodule

[hw/rtl/b2da_ctrl.sv]
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller: accept a number, run the conversion shifts, drop leading
// zeros, then hand out one digit per output request.
// ----------------------------------------------------------------------------
module b2da_ctrl import b2da_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				if (stat.last_bit) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop zero digits, but always keep the final one
				if (stat.top_zero && !stat.last_digit) begin
					cmd.advance = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last_digit) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_ready && stat.last_digit) |=> (state_q == ST_IDLE))
		else $error("converter did not return to idle after the last digit");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> (!stat.top_zero || stat.last_digit))
		else $error("first emitted digit is a leading zero");

	a_skip_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SKIP) |-> $past(stat.last_bit))
		else $error("conversion ended before all bits were shifted");

	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a digit is offered");
`endif

endmodule
